// File: hw/rtl/qhe_pkg.sv
// Shared types and constants for the quintic Hermite evaluator.
// No dependencies.
package qhe_pkg;

	// Coefficients and Horner accumulators, signed, in units of 2^-17
	localparam int COEF_W = 48;
	typedef logic signed [COEF_W-1:0] coef_t;

	// Configuration and result words, signed Q16.16
	localparam int WORD_W = 32;
	typedef logic signed [WORD_W-1:0] word_t;

	// Four curves (value and three derivatives), six coefficients each
	localparam int NUM_CURVES = 4;
	localparam int NUM_COEFS = 6;
	localparam int NUM_STEPS = NUM_COEFS - 1;

	// Configuration register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_START_VALUE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_SLOPE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_START_CURV  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_END_VALUE   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_END_SLOPE   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_END_CURV    = 3'd5;

	// Saturation limits of a result word, at accumulator width
	localparam coef_t SAT_MAX = coef_t'(64'sd2147483647);
	localparam coef_t SAT_MIN = coef_t'(-64'sd2147483648);

endpackage

// File: hw/rtl/quintic_hermite_evaluator.sv
// Quintic Hermite segment evaluator, top level.
// Depends on qhe_pkg.
//
// Usage:
//   Write the six end conditions (start/end value, slope, curvature, signed
//   Q16.16) through wr_en / wr_index / wr_data; indexes 6 and 7 are ignored.
//   The power-basis coefficients are re-derived and registered in the cycle after a write.
//   Pulse start with param_t (unsigned Q1.T_FRAC_BITS, values above one are
//   clamped to one); a transfer happens when start is high and busy is low.
//   busy stays low: a new t is taken every cycle.
//   Each transfer yields one result: done is high for exactly one cycle with
//   position, velocity, acceleration and jerk (signed Q16.16, saturated).
//   Throughput is one item per cycle. A transfer passes an entry stage,
//   five Horner steps, each a multiply stage and a round-and-add stage,
//   and an output stage.
//   The receiver cannot stall, so no backpressure exists.
//   Reset clears all valid bits and the configuration to zero, which gives
//   all-zero coefficients.
module quintic_hermite_evaluator
	import qhe_pkg::*;
#(
	parameter int T_FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [REG_IDX_W-1:0]     wr_index,
	input  logic [WORD_W-1:0]        wr_data,
	input  logic                     start,
	output logic                     busy,
	input  logic [T_FRAC_BITS:0]     param_t,
	output logic                     done,
	output logic signed [WORD_W-1:0] position,
	output logic signed [WORD_W-1:0] velocity,
	output logic signed [WORD_W-1:0] acceleration,
	output logic signed [WORD_W-1:0] jerk
);

	localparam int TW = T_FRAC_BITS + 1;
	localparam int PW = COEF_W + TW + 1;
	localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (T_FRAC_BITS - 1);

	word_t cfg_q [0:5];
	coef_t coef_q [0:NUM_CURVES-1][0:NUM_COEFS-1];
	coef_t coef_d [0:NUM_CURVES-1][0:NUM_COEFS-1];
	coef_t p0, v0, a0, p1, v1, a1, c5, c4, c3, c2, c1, c0;

	logic              vld_a_s [0:NUM_STEPS];
	logic [TW-1:0]     t_a_s   [0:NUM_STEPS];
	coef_t             acc_a_s [0:NUM_STEPS][0:NUM_CURVES-1];
	logic              vld_m_s [1:NUM_STEPS];
	logic [TW-1:0]     t_m_s   [1:NUM_STEPS];
	logic signed [PW-1:0] prod_m_s [1:NUM_STEPS][0:NUM_CURVES-1];

	coef_t res_sat [0:NUM_CURVES-1];
	word_t res_q   [0:NUM_CURVES-1];
	logic  done_q;

	assign busy = 1'b0;

	// Hold configuration registers; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) cfg_q[i] <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_VALUE: cfg_q[0] <= word_t'(wr_data);
				REG_START_SLOPE: cfg_q[1] <= word_t'(wr_data);
				REG_START_CURV:  cfg_q[2] <= word_t'(wr_data);
				REG_END_VALUE:   cfg_q[3] <= word_t'(wr_data);
				REG_END_SLOPE:   cfg_q[4] <= word_t'(wr_data);
				REG_END_CURV:    cfg_q[5] <= word_t'(wr_data);
				default: ;
			endcase
		end
	end

	// Derive power-basis coefficients; shorter curves get leading zeros
	always_comb begin
		p0 = coef_t'(cfg_q[0]);
		v0 = coef_t'(cfg_q[1]);
		a0 = coef_t'(cfg_q[2]);
		p1 = coef_t'(cfg_q[3]);
		v1 = coef_t'(cfg_q[4]);
		a1 = coef_t'(cfg_q[5]);
		c5 = coef_t'(-12 * p0 - 6 * v0 - a0 + 12 * p1 - 6 * v1 + a1);
		c4 = coef_t'(30 * p0 + 16 * v0 + 3 * a0 - 30 * p1 + 14 * v1 - 2 * a1);
		c3 = coef_t'(-20 * p0 - 12 * v0 - 3 * a0 + 20 * p1 - 8 * v1 + a1);
		c2 = a0;
		c1 = coef_t'(2 * v0);
		c0 = coef_t'(2 * p0);
		coef_d[0][0] = c5;
		coef_d[0][1] = c4;
		coef_d[0][2] = c3;
		coef_d[0][3] = c2;
		coef_d[0][4] = c1;
		coef_d[0][5] = c0;
		coef_d[1][0] = '0;
		coef_d[1][1] = coef_t'(5 * c5);
		coef_d[1][2] = coef_t'(4 * c4);
		coef_d[1][3] = coef_t'(3 * c3);
		coef_d[1][4] = coef_t'(2 * c2);
		coef_d[1][5] = c1;
		coef_d[2][0] = '0;
		coef_d[2][1] = '0;
		coef_d[2][2] = coef_t'(20 * c5);
		coef_d[2][3] = coef_t'(12 * c4);
		coef_d[2][4] = coef_t'(6 * c3);
		coef_d[2][5] = coef_t'(2 * c2);
		coef_d[3][0] = '0;
		coef_d[3][1] = '0;
		coef_d[3][2] = '0;
		coef_d[3][3] = coef_t'(60 * c5);
		coef_d[3][4] = coef_t'(24 * c4);
		coef_d[3][5] = coef_t'(6 * c3);
	end

	// Register the coefficients behind the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CURVES; c++)
				for (int k = 0; k < NUM_COEFS; k++) coef_q[c][k] <= '0;
		end else begin
			coef_q <= coef_d;
		end
	end

	// Entry stage: clamp t, load leading coefficients
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_s[0] <= 1'b0;
		end else begin
			vld_a_s[0] <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		t_a_s[0] <= (param_t > T_ONE) ? T_ONE : param_t;
		for (int c = 0; c < NUM_CURVES; c++) acc_a_s[0][c] <= coef_q[c][0];
	end

	// Horner steps: multiply stage, then round-and-add stage
	for (genvar j = 1; j <= NUM_STEPS; j++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_m_s[j] <= 1'b0;
				vld_a_s[j] <= 1'b0;
			end else begin
				vld_m_s[j] <= vld_a_s[j-1];
				vld_a_s[j] <= vld_m_s[j];
			end
		end

		always_ff @(posedge clk) begin
			t_m_s[j] <= t_a_s[j-1];
			t_a_s[j] <= t_m_s[j];
			for (int c = 0; c < NUM_CURVES; c++) begin
				prod_m_s[j][c] <= PW'(acc_a_s[j-1][c]) * PW'($signed({1'b0, t_a_s[j-1]}));
				acc_a_s[j][c] <= coef_t'((prod_m_s[j][c] + HALF) >>> T_FRAC_BITS)
					+ coef_q[c][j];
			end
		end
	end

	// Convert Q.17 to Q16.16 with round half up, then saturate
	always_comb begin
		coef_t half_v;
		for (int c = 0; c < NUM_CURVES; c++) begin
			half_v = coef_t'((acc_a_s[NUM_STEPS][c] + coef_t'(1)) >>> 1);
			if (half_v > SAT_MAX) res_sat[c] = SAT_MAX;
			else if (half_v < SAT_MIN) res_sat[c] = SAT_MIN;
			else res_sat[c] = half_v;
		end
	end

	// Output register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_a_s[NUM_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CURVES; c++) res_q[c] <= res_sat[c][WORD_W-1:0];
	end

	assign done         = done_q;
	assign position     = res_q[0];
	assign velocity     = res_q[1];
	assign acceleration = res_q[2];
	assign jerk         = res_q[3];

endmodule
